// File: design/base64_stream_encoder_unit_assert.svh
// assertion macros used by the back end of the base64 encoder rtl
`ifndef BASE64_STREAM_ENCODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define B64E_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define B64E_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/b64e_pkg.sv
// shared types, constants and the character map of the base64 encoder
`default_nettype none

package b64e_pkg;

	localparam logic [5:0] SIX_MASK = 6'h3f;
	localparam logic [7:0] PAD_CHAR = 8'h3d;
	localparam logic [7:0] PLUS_CHAR = 8'h2b;
	localparam logic [7:0] SLASH_CHAR = 8'h2f;
	localparam logic [7:0] UPPER_BASE = 8'h41;
	localparam logic [7:0] LOWER_BASE = 8'h61;
	localparam logic [7:0] DIGIT_BASE = 8'h30;

	// one classified byte: up to four characters, pad flags, index of the last one
	typedef struct packed {
		logic [3:0][5:0] sext;
		logic [3:0]      pad;
		logic [1:0]      last;
		logic            fin;
	} cmd_t;

	function automatic logic [7:0] enc_char(input logic [5:0] v, input logic pad);
		logic [5:0] s;
		logic [7:0] c;
		s = v & SIX_MASK;
		if (pad) begin
			c = PAD_CHAR;
		end else if (s < 6'd26) begin
			c = UPPER_BASE + {2'b00, s};
		end else if (s < 6'd52) begin
			c = LOWER_BASE + {2'b00, s - 6'd26};
		end else if (s < 6'd62) begin
			c = DIGIT_BASE + {2'b00, s - 6'd52};
		end else if (s == 6'd62) begin
			c = PLUS_CHAR;
		end else begin
			c = SLASH_CHAR;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: design/b64e_front.sv
// front end: takes bytes, tracks the group phase and splits each byte into characters
`default_nettype none

module b64e_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic          full,
	input  wire logic [7:0]    data_byte,
	input  wire logic          final_byte,
	output logic               wr_en,
	output b64e_pkg::cmd_t     cmd
);

	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;

	logic [1:0] phase_q;
	logic [3:0] left_q;
	logic [1:0] phase_d;
	logic [3:0] left_d;

	assign wr_en = push && !full;

	always_comb begin
		cmd = '0;
		phase_d = phase_q;
		left_d = left_q;
		case (phase_q)
			PH_1: begin
				cmd.sext[0] = {left_q[1:0], data_byte[7:4]};
				if (final_byte) begin
					cmd.sext[1] = {data_byte[3:0], 2'b00};
					cmd.pad = 4'b0100;
					cmd.last = 2'd2;
				end else begin
					cmd.last = 2'd0;
					left_d = data_byte[3:0];
					phase_d = PH_2;
				end
			end
			PH_2: begin
				cmd.sext[0] = {left_q, data_byte[7:6]};
				cmd.sext[1] = data_byte[5:0];
				cmd.last = 2'd1;
				left_d = 4'd0;
				phase_d = PH_0;
			end
			default: begin
				// phase 0, and the unused code behaves the same
				cmd.sext[0] = data_byte[7:2];
				if (final_byte) begin
					cmd.sext[1] = {data_byte[1:0], 4'b0000};
					cmd.pad = 4'b1100;
					cmd.last = 2'd3;
				end else begin
					cmd.last = 2'd0;
					left_d = {2'b00, data_byte[1:0]};
					phase_d = PH_1;
				end
			end
		endcase
		cmd.fin = final_byte;
		if (final_byte) begin
			phase_d = PH_0;
			left_d = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_0;
			left_q <= 4'd0;
		end else if (wr_en) begin
			phase_q <= phase_d;
			left_q <= left_d;
		end
	end

endmodule

`default_nettype wire

// File: design/b64e_cmd_fifo.sv
// short queue of classified bytes between front and back ends
`default_nettype none

module b64e_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire b64e_pkg::cmd_t    wr_cmd,
	input  wire logic              rd_en,
	output logic                   full,
	output logic                   head_valid,
	output b64e_pkg::cmd_t         head_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64e_pkg::cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/b64e_back.sv
// back end: walks the characters of the head entry into the result register
`default_nettype none

module b64e_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire b64e_pkg::cmd_t    head_cmd,
	input  wire logic              pop,
	output logic                   rd_en,
	output logic                   empty,
	output logic [7:0]             ascii_char,
	output logic                   end_of_text
);

	`include "base64_stream_encoder_unit_assert.svh"

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       eot_q;
	logic       adv;
	logic       at_last;

	assign empty = !valid_q;
	assign ascii_char = char_q;
	assign end_of_text = eot_q;

	// the result register frees up when empty or being taken this cycle
	assign adv = head_valid && (!valid_q || pop);
	assign at_last = (idx_q == head_cmd.last);
	assign rd_en = adv && at_last;

	always_ff @(posedge clk) begin
		if (adv) begin
			char_q <= b64e_pkg::enc_char(head_cmd.sext[idx_q], head_cmd.pad[idx_q]);
			eot_q <= head_cmd.fin && at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
			if (adv) begin
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	`B64E_ASSERT_NOW(a_idx_in_range, head_valid, idx_q <= head_cmd.last, "char index past entry end")
	`B64E_ASSERT_NOW(a_partial_has_head, idx_q != 2'd0, head_valid, "partial entry lost its head")
	`B64E_ASSERT_NEXT(a_eot_restarts, adv && head_cmd.fin && at_last, idx_q == 2'd0 && eot_q, "message end not marked")

endmodule

`default_nettype wire

// File: design/base64_stream_encoder_unit.sv
// top level of the streaming base64 encoder
// a byte's request is written into the queue, and its first character then passes through the result
// register, from where it can be popped
// throughput: one character per cycle out of the single result register, while pop is held and the queue is not empty
// a plain byte makes one or two characters, and the front takes new bytes while the back drains earlier ones
// a final byte makes up to four characters and holds its queue slot until its last one is loaded
// reset: arst_n clears the group phase and leftover bits, the queue pointers, the character
// index and the result valid flag
`default_nettype none

module base64_stream_encoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      ascii_char,
	output logic            end_of_text
);

	// front to queue
	logic           wr_en;
	b64e_pkg::cmd_t wr_cmd;

	// queue to back
	logic           head_valid;
	b64e_pkg::cmd_t head_cmd;
	logic           rd_en;

	// front end: classifies each request by group phase into a list of characters
	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.wr_en      (wr_en),
		.cmd        (wr_cmd)
	);

	// short queue so the front keeps taking bytes while the back drains characters
	b64e_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_cmd     (wr_cmd),
		.rd_en      (rd_en),
		.full       (full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// back end: maps one six-bit code per cycle to ascii into the result register while it is free
	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.rd_en       (rd_en),
		.empty       (empty),
		.ascii_char  (ascii_char),
		.end_of_text (end_of_text)
	);

endmodule

`default_nettype wire
